// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used in the cluster chain engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FCCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FCCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== sv/fcce_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine package
// Widths and codes shared by all modules, and the command and status records.
// ----------------------------------------------------------------------------
package fcce_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LIM_W       = 17;   // holds cluster_count + 2 and TABLE_DEPTH

    // Field widths.
    localparam int CMD_W = 3;
    localparam int VAL_W = 16;
    localparam int CNT_W = 12;
    localparam int STS_W = 2;

    // Entry marks.
    localparam logic [VAL_W-1:0] CHAIN_LIMIT = 16'hFFF8;
    localparam logic [VAL_W-1:0] END_MARK    = 16'hFFFF;
    localparam logic [VAL_W-1:0] FREE_MARK   = 16'h0000;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LINK  = 3'd4;

    // Result status codes.
    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STS_W-1:0] ST_BAD  = 2'd2;
    localparam logic [STS_W-1:0] ST_LOOP = 2'd3;

    // Table write selects.
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_CLR   = 3'd1;  // clearing pass
    localparam logic [2:0] WR_ENTRY = 3'd2;  // table[tail] = entry value
    localparam logic [2:0] WR_FREE  = 3'd3;  // table[cur]  = free mark
    localparam logic [2:0] WR_END   = 3'd4;  // table[cur]  = end mark
    localparam logic [2:0] WR_LINK  = 3'd5;  // table[tail] = cur

    // Cursor updates.
    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_TWO  = 2'd1;
    localparam logic [1:0] CUR_INC  = 2'd2;
    localparam logic [1:0] CUR_NEXT = 2'd3;

    // Staged result value selects.
    localparam logic [1:0] STG_ZERO  = 2'd0;
    localparam logic [1:0] STG_RDATA = 2'd1;
    localparam logic [1:0] STG_CUR   = 2'd2;

    typedef struct packed {
        logic             load;
        logic             rd_cur;
        logic             rd_tail;
        logic [2:0]       wr_sel;
        logic [1:0]       cur_sel;
        logic             freed_inc;
        logic             stg_load;
        logic [1:0]       stg_sel;
        logic [STS_W-1:0] stg_sts;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic tail_lt2;
        logic tail_ge_lim;
        logic cur_ge_lim;
        logic cur_is_link;
        logic rdata_zero;
        logic rdata_link;
        logic freed_max;
        logic clr_last;
    } t_dp_sts;

    // A value that points on to another cluster of a chain.
    function automatic logic is_link(input logic [VAL_W-1:0] v);
        return (v >= 16'd2) && (v < CHAIN_LIMIT);
    endfunction

endpackage

// ===== sv/fcce_ifs.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine channels
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
interface fcce_item_if import fcce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] cluster;
    logic [VAL_W-1:0] entry_value;

    modport source (output valid, output cmd, output cluster, output entry_value,
                    input ready);
    modport sink   (input valid, input cmd, input cluster, input entry_value,
                    output ready);
endinterface

interface fcce_result_if import fcce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] result_value;
    logic [STS_W-1:0] status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

interface fcce_cfg_if import fcce_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] cluster_count;

    modport source (output valid, output cluster_count, input ready);
    modport sink   (input valid, input cluster_count, output ready);
endinterface

// ===== sv/fcce_datapath.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine datapath
// Cluster table memory, cursor and tail registers, limit compares, results.
// ----------------------------------------------------------------------------
module fcce_datapath import fcce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_cfg_wr,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic [VAL_W-1:0] i_cluster,
    input  logic [VAL_W-1:0] i_entry_value,
    output logic [VAL_W-1:0] o_result_value,
    output logic [STS_W-1:0] o_status
);

    logic [VAL_W-1:0]  r_table [TABLE_DEPTH];
    logic [VAL_W-1:0]  r_rdata;

    logic [CNT_W-1:0]  r_cluster_count;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [VAL_W-1:0]  r_cur,  n_cur;
    logic [VAL_W-1:0]  r_tail;
    logic [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_freed;
    logic [VAL_W-1:0]  r_stg_val, n_stg_val;
    logic [STS_W-1:0]  r_stg_sts;
    logic [VAL_W-1:0]  r_out_val;
    logic [STS_W-1:0]  r_out_sts;

    logic [LIM_W-1:0]  w_sum;
    logic [LIM_W-1:0]  w_lim;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;

    // Usable limit is cluster_count + 2, capped at the table depth.
    assign w_sum = LIM_W'(r_cluster_count) + LIM_W'(2);
    assign w_lim = (w_sum > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : w_sum;

    always_comb begin
        o_sts.tail_lt2    = r_tail < 16'd2;
        o_sts.tail_ge_lim = LIM_W'(r_tail) >= w_lim;
        o_sts.cur_ge_lim  = LIM_W'(r_cur) >= w_lim;
        o_sts.cur_is_link = is_link(r_cur);
        o_sts.rdata_zero  = r_rdata == FREE_MARK;
        o_sts.rdata_link  = is_link(r_rdata);
        o_sts.freed_max   = r_freed >= r_cluster_count;
        o_sts.clr_last    = r_clr_addr == ADDR_W'(TABLE_DEPTH - 1);
    end

    // Table port selection.
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_clr_addr;
        w_wdata = FREE_MARK;
        case (i_cmd.wr_sel)
            WR_CLR: begin
                w_waddr = r_clr_addr;
                w_wdata = FREE_MARK;
            end
            WR_ENTRY: begin
                w_waddr = r_tail[ADDR_W-1:0];
                w_wdata = r_val;
            end
            WR_FREE: begin
                w_waddr = r_cur[ADDR_W-1:0];
                w_wdata = FREE_MARK;
            end
            WR_END: begin
                w_waddr = r_cur[ADDR_W-1:0];
                w_wdata = END_MARK;
            end
            WR_LINK: begin
                w_waddr = r_tail[ADDR_W-1:0];
                w_wdata = r_cur;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_re    = i_cmd.rd_cur | i_cmd.rd_tail;
    assign w_raddr = i_cmd.rd_tail ? r_tail[ADDR_W-1:0] : r_cur[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_table[w_raddr];
        end
    end

    always_comb begin
        case (i_cmd.cur_sel)
            CUR_TWO:  n_cur = 16'd2;
            CUR_INC:  n_cur = r_cur + 16'd1;
            CUR_NEXT: n_cur = r_rdata;
            default:  n_cur = r_cur;
        endcase
        case (i_cmd.stg_sel)
            STG_RDATA: n_stg_val = r_rdata;
            STG_CUR:   n_stg_val = r_cur;
            default:   n_stg_val = FREE_MARK;
        endcase
    end

    // Control registers: configuration and clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= '0;
            r_clr_addr      <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_cluster_count <= i_cfg_data;
            end
            if (i_cmd.wr_sel == WR_CLR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur   <= i_cluster;
            r_tail  <= i_cluster;
            r_val   <= i_entry_value;
            r_freed <= '0;
        end else begin
            r_cur <= n_cur;
            if (i_cmd.freed_inc) begin
                r_freed <= r_freed + CNT_W'(1);
            end
        end
        if (i_cmd.stg_load) begin
            r_stg_val <= n_stg_val;
            r_stg_sts <= i_cmd.stg_sts;
        end
        if (i_cmd.out_load) begin
            r_out_val <= r_stg_val;
            r_out_sts <= r_stg_sts;
        end
    end

    assign o_result_value = r_out_val;
    assign o_status       = r_out_sts;

endmodule

// ===== sv/fcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine controller
// Sequences the clearing pass, command decode, scans, chain walks and output.
// ----------------------------------------------------------------------------
module fcce_ctrl import fcce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_dp_cmd          o_cmd,
    input  t_dp_sts          i_sts
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISP      = 4'd2;
    localparam logic [3:0] S_RD_WAIT   = 4'd3;
    localparam logic [3:0] S_TAIL_CHK  = 4'd4;
    localparam logic [3:0] S_SCAN_RD   = 4'd5;
    localparam logic [3:0] S_SCAN_CHK  = 4'd6;
    localparam logic [3:0] S_LINK      = 4'd7;
    localparam logic [3:0] S_FREE_TEST = 4'd8;
    localparam logic [3:0] S_FREE_STEP = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CMD_W-1:0] r_cmd,   n_cmd;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        o_in_ready = 1'b0;
        o_cmd      = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_sel = WR_CLR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cmd      = i_in_cmd;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.stg_sel = STG_ZERO;
                o_cmd.stg_sts = ST_OK;
                case (r_cmd)
                    CMD_READ: begin
                        if (i_sts.tail_ge_lim) begin
                            o_cmd.stg_load = 1'b1;
                            o_cmd.stg_sts  = ST_BAD;
                            n_state        = S_OUT;
                        end else begin
                            o_cmd.rd_tail = 1'b1;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    CMD_WRITE: begin
                        o_cmd.stg_load = 1'b1;
                        if (i_sts.tail_ge_lim) begin
                            o_cmd.stg_sts = ST_BAD;
                        end else begin
                            o_cmd.wr_sel = WR_ENTRY;
                        end
                        n_state = S_OUT;
                    end
                    CMD_ALLOC: begin
                        o_cmd.cur_sel = CUR_TWO;
                        n_state       = S_SCAN_RD;
                    end
                    CMD_FREE: begin
                        n_state = S_FREE_TEST;
                    end
                    CMD_LINK: begin
                        if (i_sts.tail_lt2 || i_sts.tail_ge_lim) begin
                            o_cmd.stg_load = 1'b1;
                            o_cmd.stg_sts  = ST_BAD;
                            n_state        = S_OUT;
                        end else begin
                            o_cmd.rd_tail = 1'b1;
                            n_state       = S_TAIL_CHK;
                        end
                    end
                    default: begin
                        o_cmd.stg_load = 1'b1;
                        n_state        = S_OUT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.stg_load = 1'b1;
                o_cmd.stg_sel  = STG_RDATA;
                o_cmd.stg_sts  = ST_OK;
                n_state        = S_OUT;
            end
            S_TAIL_CHK: begin
                if (i_sts.rdata_link) begin
                    o_cmd.stg_load = 1'b1;
                    o_cmd.stg_sel  = STG_RDATA;
                    o_cmd.stg_sts  = ST_OK;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.cur_sel = CUR_TWO;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.cur_ge_lim) begin
                    o_cmd.stg_load = 1'b1;
                    o_cmd.stg_sel  = STG_ZERO;
                    o_cmd.stg_sts  = ST_FULL;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.rdata_zero) begin
                    o_cmd.wr_sel = WR_END;
                    if (r_cmd == CMD_LINK) begin
                        n_state = S_LINK;
                    end else begin
                        o_cmd.stg_load = 1'b1;
                        o_cmd.stg_sel  = STG_CUR;
                        o_cmd.stg_sts  = ST_OK;
                        n_state        = S_OUT;
                    end
                end else begin
                    o_cmd.cur_sel = CUR_INC;
                    n_state       = S_SCAN_RD;
                end
            end
            S_LINK: begin
                o_cmd.wr_sel   = WR_LINK;
                o_cmd.stg_load = 1'b1;
                o_cmd.stg_sel  = STG_CUR;
                o_cmd.stg_sts  = ST_OK;
                n_state        = S_OUT;
            end
            S_FREE_TEST: begin
                o_cmd.stg_sel = STG_ZERO;
                if (!i_sts.cur_is_link) begin
                    o_cmd.stg_load = 1'b1;
                    o_cmd.stg_sts  = ST_OK;
                    n_state        = S_OUT;
                end else if (i_sts.cur_ge_lim) begin
                    o_cmd.stg_load = 1'b1;
                    o_cmd.stg_sts  = ST_BAD;
                    n_state        = S_OUT;
                end else if (i_sts.freed_max) begin
                    o_cmd.stg_load = 1'b1;
                    o_cmd.stg_sts  = ST_LOOP;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_FREE_STEP;
                end
            end
            S_FREE_STEP: begin
                o_cmd.wr_sel    = WR_FREE;
                o_cmd.cur_sel   = CUR_NEXT;
                o_cmd.freed_inc = 1'b1;
                n_state         = S_FREE_TEST;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cmd       <= CMD_READ;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/fat16_cluster_chain_engine_top.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine
// Read, write, allocate, allocate-and-link and chain free on a FAT16 table.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Payload                           Beat moves
//   i_item     in   cmd, cluster, entry_value         one command
//   o_result   out  result_value, status              one result per command
//   i_cfg      in   cluster_count                     one register write
//
// After reset a clearing pass zeroes the table one entry a cycle; i_item.ready
// stays low during it, while configuration beats are taken at every cycle.
// A read passes through the idle, dispatch, read-wait and output states, a
// write through the idle, dispatch and output states. Allocation tests one
// entry at a time in the scan-read and scan-check states, set by the single
// registered table read port, and may scan every entry of a full table.
// A chain free walks the chain one link at a time, test state then step state.
// One command is worked at a time; the next command is taken while the
// previous result waits in the output register, and a finished result that
// finds the output register still full holds off the command input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat16_cluster_chain_engine_top import fcce_pkg::*; (
    input logic           i_clk,
    input logic           i_rst_n,
    fcce_item_if.sink     i_item,
    fcce_result_if.source o_result,
    fcce_cfg_if.sink      i_cfg
);

    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;
    logic    w_cfg_wr;

    // The configuration register is always writable; the contract only writes
    // it while no command is in flight.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid & i_cfg.ready;

    // The controller owns all sequencing: the clearing pass, command decode,
    // the free-entry scan, the chain walk and the output handoff.
    fcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_cmd    (i_item.cmd),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_dp_cmd),
        .i_sts       (w_dp_sts)
    );

    // The datapath holds the table memory, the cursor and tail registers,
    // the limit compares and the staged and output result registers.
    fcce_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_dp_cmd),
        .o_sts          (w_dp_sts),
        .i_cfg_wr       (w_cfg_wr),
        .i_cfg_data     (i_cfg.cluster_count),
        .i_cluster      (i_item.cluster),
        .i_entry_value  (i_item.entry_value),
        .o_result_value (o_result.result_value),
        .o_status       (o_result.status)
    );

    // No command is taken while the clearing pass is still running.
    `FCCE_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n,
        w_dp_cmd.wr_sel == WR_CLR, !i_item.ready)

    // Commands are worked one at a time.
    `FCCE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n,
        i_item.valid && i_item.ready, !i_item.ready)

    // A result only enters the output register when the slot is free.
    `FCCE_ASSERT_IMP(a_out_slot_free, i_clk, i_rst_n,
        w_dp_cmd.out_load, !o_result.valid || o_result.ready)

    // A chain walk only zeroes entries inside the usable table.
    `FCCE_ASSERT_IMP(a_free_in_table, i_clk, i_rst_n,
        w_dp_cmd.wr_sel == WR_FREE, !w_dp_sts.cur_ge_lim)

endmodule

// ===== tb/fcce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine result checker
// Watches the command, result and configuration channels. It keeps its own
// copy of the cluster table, works out the reply to every accepted command
// and compares each result beat with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module fcce_checker import fcce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcce_item_if        i_item,
    fcce_result_if      i_result,
    fcce_cfg_if         i_cfg,
    output int unsigned o_errors,
    output int unsigned o_pending,
    output int unsigned o_checked
);

    localparam int unsigned DATA_BASE = 2;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [STS_W-1:0] status;
    } t_fat_reply;

    logic [VAL_W-1:0] fat_map [TABLE_DEPTH];
    logic [CNT_W-1:0] usable_clusters;
    t_fat_reply       awaited_replies [$];
    int unsigned      mismatch_count = 0;
    int unsigned      compared_count = 0;

    task automatic note_mismatch(input string msg);
        $display("[%0t] cluster table mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Entries at or above this index lie outside the table.
    function automatic int unsigned map_limit();
        int unsigned lim;
        lim = usable_clusters + DATA_BASE;
        if (lim > TABLE_DEPTH)
            lim = TABLE_DEPTH;
        return lim;
    endfunction

    function automatic logic points_on(input logic [VAL_W-1:0] v);
        return (v >= DATA_BASE) && (v < CHAIN_LIMIT);
    endfunction

    // First free entry from cluster 2 up becomes an end of chain; none gives 0.
    function automatic logic [VAL_W-1:0] claim_free();
        int unsigned lim;
        lim = map_limit();
        for (int unsigned c = DATA_BASE; c < lim; c++) begin
            if (fat_map[c] == FREE_MARK) begin
                fat_map[c] = END_MARK;
                return VAL_W'(c);
            end
        end
        return '0;
    endfunction

    function automatic logic [STS_W-1:0] release_chain(input logic [VAL_W-1:0] start);
        int unsigned      lim;
        int unsigned      freed;
        logic [VAL_W-1:0] at;
        logic [VAL_W-1:0] nxt;
        lim   = map_limit();
        freed = 0;
        at    = start;
        while (points_on(at)) begin
            if (at >= lim)
                return ST_BAD;
            if (freed >= usable_clusters)
                return ST_LOOP;
            nxt         = fat_map[at];
            fat_map[at] = FREE_MARK;
            freed++;
            at = nxt;
        end
        return ST_OK;
    endfunction

    function automatic t_fat_reply fat_outcome(input logic [CMD_W-1:0] cmd,
                                               input logic [VAL_W-1:0] cl,
                                               input logic [VAL_W-1:0] v);
        t_fat_reply  r;
        int unsigned lim;
        r.value  = '0;
        r.status = ST_OK;
        lim      = map_limit();
        case (cmd)
            CMD_READ: begin
                if (cl < lim)
                    r.value = fat_map[cl];
                else
                    r.status = ST_BAD;
            end
            CMD_WRITE: begin
                if (cl < lim)
                    fat_map[cl] = v;
                else
                    r.status = ST_BAD;
            end
            CMD_ALLOC: begin
                r.value = claim_free();
                if (r.value == '0)
                    r.status = ST_FULL;
            end
            CMD_FREE: begin
                r.status = release_chain(cl);
            end
            CMD_LINK: begin
                if (cl < DATA_BASE || cl >= lim) begin
                    r.status = ST_BAD;
                end else if (points_on(fat_map[cl])) begin
                    r.value = fat_map[cl];
                end else begin
                    r.value = claim_free();
                    if (r.value == '0)
                        r.status = ST_FULL;
                    else
                        fat_map[cl] = r.value;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_fat_reply want;
        if (!i_rst_n) begin
            foreach (fat_map[k])
                fat_map[k] = FREE_MARK;
            usable_clusters = '0;
            awaited_replies.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                usable_clusters = i_cfg.cluster_count;
            // Results first, so a beat can never be matched to a command
            // accepted at the same edge.
            if (i_result.valid && i_result.ready) begin
                if (awaited_replies.size() == 0) begin
                    note_mismatch($sformatf("result 0x%0h status %0d with no command open",
                                            i_result.result_value, i_result.status));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_result.result_value !== want.value)
                        note_mismatch($sformatf("reply %0d result_value 0x%0h, expected 0x%0h",
                                                compared_count, i_result.result_value,
                                                want.value));
                    if (i_result.status !== want.status)
                        note_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                                compared_count, i_result.status,
                                                want.status));
                    compared_count++;
                end
            end
            if (i_item.valid && i_item.ready)
                awaited_replies.push_back(fat_outcome(i_item.cmd, i_item.cluster,
                                                      i_item.entry_value));
        end
        o_pending <= awaited_replies.size();
        o_errors  <= mismatch_count;
        o_checked <= compared_count;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT16 cluster chain engine testbench
// Drives commands and cluster_count writes into the engine, stalls the result
// side at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
    import fcce_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 8;
    // The result side stops taking beats for a long stretch after this many
    // results, which falls inside the first random phase.
    localparam int STALL_AT_BEAT = 40;
    localparam int STALL_CYCLES  = 600;
    // Longest commands scan the whole table, as an allocation scan does.
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 64;
    // The slowest legal run (clearing pass plus every command a full scan)
    // stays near 14 ms; this leaves a wide margin.
    localparam longint RUN_LIMIT_NS = 100_000_000;

    localparam int unsigned      DATA_BASE    = 2;
    localparam int unsigned      HOT_TOP      = 33;
    localparam int unsigned      MAX_CLUSTERS = 4094;
    localparam logic [CMD_W-1:0] CMD_SPARE    = '1;

    logic i_clk;
    logic i_rst_n;

    fcce_item_if   item_ch ();
    fcce_result_if result_ch ();
    fcce_cfg_if    cfg_ch ();

    int unsigned      mismatches;
    int unsigned      outstanding;
    int unsigned      compared;
    int unsigned      commands_sent;
    int unsigned      sizes_used;

    // Counters of zero-gap stretches, one per side.
    int unsigned send_calm = 0;
    int unsigned take_calm = 0;

    fat16_cluster_chain_engine_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    fcce_checker watch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (mismatches),
        .o_pending (outstanding),
        .o_checked (compared)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Idle cycles before the next beat on either side. Now and then a run of
    // beats goes through with no gap at all, so back-to-back traffic is seen
    // as well as gaps on every phase of the engine's work.
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(6, 20);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // One command beat. Valid stays high into the next call when that call
    // draws no gap, so it is never lowered and raised in the same step.
    task automatic offer_command(input logic [CMD_W-1:0] c,
                                 input logic [VAL_W-1:0] cl,
                                 input logic [VAL_W-1:0] v);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= c;
        item_ch.cluster     <= cl;
        item_ch.entry_value <= v;
        do @(posedge i_clk); while (!item_ch.ready);
        commands_sent++;
    endtask

    // Ends a phase: no more commands, then wait until every reply is in.
    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Only called with the engine idle, right after reset or a drain.
    task automatic set_cluster_count(input logic [CNT_W-1:0] n);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.cluster_count <= n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sizes_used++;
    endtask

    // Random commands at one table size. Most indices fall in a hot window
    // from cluster 2 up, where allocation puts clusters, so that links and
    // frees meet real chains; the rest probe the table edge, entries 0 and
    // 1, the whole table, the end-of-chain range and the whole 16-bit space.
    task automatic run_random_phase(input logic [CNT_W-1:0] n, input int unsigned items);
        int unsigned      lim;
        int unsigned      hot_hi;
        int unsigned      pick;
        logic [CMD_W-1:0] c;
        logic [VAL_W-1:0] cl;
        logic [VAL_W-1:0] v;
        set_cluster_count(n);
        lim = n + DATA_BASE;
        if (lim > TABLE_DEPTH)
            lim = TABLE_DEPTH;
        if (lim > DATA_BASE + 1)
            hot_hi = (lim - 1 < HOT_TOP) ? lim - 1 : HOT_TOP;
        else
            hot_hi = DATA_BASE;
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                c = CMD_READ;
            else if (pick < 42)
                c = CMD_WRITE;
            else if (pick < 57)
                c = CMD_ALLOC;
            else if (pick < 72)
                c = CMD_FREE;
            else if (pick < 95)
                c = CMD_LINK;
            else
                c = CMD_W'($urandom_range(CMD_LINK + 1, CMD_SPARE));

            pick = $urandom_range(0, 19);
            if (pick < 12)
                cl = VAL_W'($urandom_range(DATA_BASE, hot_hi));
            else if (pick < 15)
                cl = VAL_W'($urandom_range(lim - 2, lim + 1));
            else if (pick < 16)
                cl = VAL_W'($urandom_range(0, 1));
            else if (pick < 18)
                cl = VAL_W'($urandom_range(0, lim - 1));
            else if (pick < 19)
                cl = VAL_W'($urandom());
            else
                cl = VAL_W'($urandom_range(CHAIN_LIMIT - 2, END_MARK));

            // Written values are mostly links into the hot window, so that
            // chains and loops build up, or end-of-chain marks.
            pick = $urandom_range(0, 19);
            if (pick < 10)
                v = VAL_W'($urandom_range(DATA_BASE, hot_hi));
            else if (pick < 13)
                v = VAL_W'($urandom_range(CHAIN_LIMIT, END_MARK));
            else if (pick < 15)
                v = FREE_MARK;
            else if (pick < 17)
                v = VAL_W'($urandom());
            else if (pick < 18)
                v = VAL_W'($urandom_range(0, 1));
            else
                v = VAL_W'($urandom_range(0, lim + 2));

            offer_command(c, cl, v);
        end
        drain();
    endtask

    // Result side. Every beat waits a drawn number of cycles; once, the side
    // holds off for a long stretch while commands keep coming, so the
    // output register fills and the engine must stall its command input.
    initial begin : result_side
        int unsigned hold;
        int unsigned taken;
        taken           = 0;
        result_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            hold = draw_gap(take_calm);
            if (hold != 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            taken++;
            if (taken == STALL_AT_BEAT) begin
                result_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.cmd          = CMD_READ;
        item_ch.cluster      = '0;
        item_ch.entry_value  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.cluster_count = '0;
        commands_sent        = 0;
        sizes_used           = 1;   // the reset value counts as one setting

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With cluster_count at its reset value of zero only entries 0 and
        // 1 exist. The first command waits out the clearing pass.
        offer_command(CMD_READ, 16'd0, FREE_MARK);
        offer_command(CMD_WRITE, 16'd1, END_MARK);
        offer_command(CMD_READ, 16'd1, FREE_MARK);
        offer_command(CMD_READ, 16'd2, FREE_MARK);           // at the limit
        offer_command(CMD_ALLOC, 16'd0, FREE_MARK);          // nothing to allocate
        offer_command(CMD_LINK, 16'd2, FREE_MARK);           // tail outside the table
        offer_command(CMD_FREE, CHAIN_LIMIT - 1, FREE_MARK); // start past the table
        offer_command(CMD_SPARE, END_MARK, END_MARK);        // unused command
        drain();

        // One usable cluster. Linking after a free tail hands the tail its
        // own index, and freeing that self-link trips the walk counter.
        set_cluster_count(12'd1);
        offer_command(CMD_LINK, 16'd2, FREE_MARK);
        offer_command(CMD_LINK, 16'd2, FREE_MARK);           // link already there
        offer_command(CMD_FREE, 16'd2, FREE_MARK);
        offer_command(CMD_ALLOC, 16'd0, FREE_MARK);
        offer_command(CMD_ALLOC, 16'd0, FREE_MARK);          // table full
        offer_command(CMD_LINK, 16'd2, FREE_MARK);           // full, tail unchanged
        drain();

        // Six clusters: a ring through all of them is freed and stopped as a
        // loop, a chain that runs off the table stops with a bad index, and
        // a start at an end-of-chain value frees nothing.
        set_cluster_count(12'd6);
        for (int unsigned k = DATA_BASE; k < 8; k++)
            offer_command(CMD_WRITE, VAL_W'(k), (k == 7) ? 16'd2 : VAL_W'(k + 1));
        offer_command(CMD_FREE, 16'd2, FREE_MARK);
        offer_command(CMD_WRITE, 16'd2, 16'h0100);
        offer_command(CMD_FREE, 16'd2, FREE_MARK);
        offer_command(CMD_FREE, CHAIN_LIMIT, FREE_MARK);
        offer_command(CMD_LINK, 16'd7, FREE_MARK);
        drain();

        // Random phases over small, largest, middle and zero table sizes.
        run_random_phase(12'd6, 30);
        run_random_phase(CNT_W'(MAX_CLUSTERS), 30);
        run_random_phase(CNT_W'($urandom_range(7, MAX_CLUSTERS - 1)), 25);
        run_random_phase(CNT_W'($urandom_range(2, 12)), 20);
        run_random_phase('0, 10);

        // Any stray result would still show up within one full scan.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands at %0d cluster_count settings, 0 and %0d among them.",
                 commands_sent, sizes_used, MAX_CLUSTERS);
        $display("%0d results compared, after one %0d-cycle hold-off on the result side.",
                 compared, STALL_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d replies outstanding.", outstanding);
        $display("simulation failed");
        $finish;
    end

endmodule
